// ===== rtl/ssc_pkg.sv =====
// ---------------------------------------------------------------------------
// ssc_pkg
// Shared types, constants and the segment lookup for the scan counter.
// ---------------------------------------------------------------------------
package ssc_pkg;

    localparam int DIGITS     = 4;
    localparam int SEG_BITS   = 8;
    localparam int DIG_W      = $clog2(DIGITS);
    localparam int BIT_W      = $clog2(SEG_BITS);
    localparam int HOLD_W     = 8;
    localparam int COUNT_W    = 14;
    localparam int ADDR_W     = 3;

    localparam logic [COUNT_W-1:0] MAX_COUNT      = 14'd9999;
    localparam logic [HOLD_W-1:0]  HOLD_RESET     = 8'd20;
    localparam logic [COUNT_W-1:0] LIMIT_RESET    = 14'd9999;

    // register indexes, selected by paddr[2]
    localparam logic REG_HOLD  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    typedef enum logic [3:0] {
        PH_CLK_HIGH = 4'b0001,
        PH_CLK_LOW  = 4'b0010,
        PH_LATCH    = 4'b0100,
        PH_HOLD     = 4'b1000
    } ssc_phase_t;

    typedef struct packed {
        logic [HOLD_W-1:0]  hold_ticks;
        logic [COUNT_W-1:0] count_limit;
    } ssc_cfg_t;

    typedef struct packed {
        logic               serial_data;
        logic               shift_clock;
        logic               latch_strobe;
        logic [DIGITS-1:0]  digit_enable;
        logic [COUNT_W-1:0] shown_count;
    } ssc_result_t;

    // common-anode segment pattern of one decimal digit
    function automatic logic [SEG_BITS-1:0] seg_lookup(input logic [3:0] digit);
        logic [7:0] pattern;
        begin
            unique case (digit)
                4'd0: pattern = 8'hC0;
                4'd1: pattern = 8'hF9;
                4'd2: pattern = 8'hA4;
                4'd3: pattern = 8'hB0;
                4'd4: pattern = 8'h99;
                4'd5: pattern = 8'h92;
                4'd6: pattern = 8'h82;
                4'd7: pattern = 8'hF8;
                4'd8: pattern = 8'h80;
                4'd9: pattern = 8'h90;
                default: pattern = 8'hC0;
            endcase
            seg_lookup = pattern[SEG_BITS-1:0];
        end
    endfunction

endpackage

// ===== rtl/seven_segment_scan_counter.sv =====
// ---------------------------------------------------------------------------
// seven_segment_scan_counter
// Four-digit multiplexed seven-segment driver with a free-running count.
// ---------------------------------------------------------------------------
// Every input transaction is one time step and returns one result transaction
// with the pin levels of the step the sequencer is in; a tick of 1 then moves
// the sequencer on, a tick of 0 leaves it. One transaction is taken per clock:
// the sequencer state and the pin decode sit in front of a single result
// register, so each result shows in the cycle after; s_ready only drops while a result
// waits and m_ready is low. Per digit (thousands first) the segment byte goes
// out LSB first over 16 ticks, the latch pulses one tick, then the digit is
// enabled for digit_hold_ticks ticks (0 acts as 1). After the units digit the
// count steps, wrapping to 0 once it reaches count_limit (capped at 9999).
// Registers: 0x0 digit_hold_ticks, 0x4 count_limit.
// ---------------------------------------------------------------------------
module seven_segment_scan_counter
    import ssc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_tick,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_serial_data,
    output logic               m_shift_clock,
    output logic               m_latch_strobe,
    output logic [DIGITS-1:0]  m_digit_enable,
    output logic [COUNT_W-1:0] m_shown_count
);

    ssc_cfg_t    cfg;
    ssc_result_t step_result;
    ssc_result_t result_reg;
    logic        valid_reg, valid_next;
    logic        s_accept;

    ssc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_ready  = !valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    ssc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .adv     (s_accept && s_tick),
        .result  (step_result)
    );

    always_comb begin
        valid_next = valid_reg;
        if (s_accept) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= step_result;
        end
    end

    assign m_valid        = valid_reg;
    assign m_serial_data  = result_reg.serial_data;
    assign m_shift_clock  = result_reg.shift_clock;
    assign m_latch_strobe = result_reg.latch_strobe;
    assign m_digit_enable = result_reg.digit_enable;
    assign m_shown_count  = result_reg.shown_count;

    // at most one digit driven at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0(m_digit_enable))
        else $error("more than one digit enabled");

    // digit drive never overlaps shifting or latching
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_digit_enable != '0) |-> (!m_shift_clock && !m_latch_strobe))
        else $error("digit enabled during shift or latch");

    // latch and shift clock are separate steps
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_shift_clock && m_latch_strobe))
        else $error("latch and shift clock both high");

    // shown count stays decimal four digits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_shown_count <= MAX_COUNT))
        else $error("shown count out of range");

endmodule

// ===== rtl/ssc_cfg.sv =====
// ---------------------------------------------------------------------------
// ssc_cfg
// APB register file: digit hold ticks and count limit.
// ---------------------------------------------------------------------------
module ssc_cfg
    import ssc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output ssc_cfg_t          cfg
);

    logic [HOLD_W-1:0]  hold_reg,  hold_next;
    logic [COUNT_W-1:0] limit_reg, limit_next;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        hold_next  = hold_reg;
        limit_next = limit_reg;
        if (wr_en) begin
            unique case (paddr[2])
                REG_HOLD:  hold_next  = pwdata[HOLD_W-1:0];
                REG_LIMIT: limit_next = pwdata[COUNT_W-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg  <= HOLD_RESET;
            limit_reg <= LIMIT_RESET;
        end else begin
            hold_reg  <= hold_next;
            limit_reg <= limit_next;
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_HOLD:  prdata = {{(32-HOLD_W){1'b0}}, hold_reg};
            REG_LIMIT: prdata = {{(32-COUNT_W){1'b0}}, limit_reg};
            default:   prdata = 32'd0;
        endcase
    end

    assign cfg.hold_ticks  = hold_reg;
    assign cfg.count_limit = limit_reg;

endmodule

// ===== rtl/ssc_seq.sv =====
// ---------------------------------------------------------------------------
// ssc_seq
// Scan sequencer: phase, digit, bit and hold counters plus the count kept
// in binary and in BCD, with the pin levels of the current step.
// ---------------------------------------------------------------------------
module ssc_seq
    import ssc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  ssc_cfg_t    cfg,
    input  logic        adv,
    output ssc_result_t result
);

    ssc_phase_t         phase_reg, phase_next;
    logic [DIG_W-1:0]   digit_reg, digit_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic [HOLD_W-1:0]  hold_cnt_reg, hold_cnt_next;
    logic               data_reg, data_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [3:0]         bcd_reg [DIGITS];
    logic [3:0]         bcd_next [DIGITS];

    logic [SEG_BITS-1:0] segments;
    logic [HOLD_W-1:0]   hold_eff;
    logic [HOLD_W-1:0]   hold_inc;
    logic [COUNT_W-1:0]  limit_eff;
    logic                carry;
    logic                data_now;

    // bcd_reg[0] is units, so thousands-first index maps to the top digit
    assign segments  = seg_lookup(bcd_reg[DIG_W'(DIGITS-1) - digit_reg]);
    assign hold_eff  = (cfg.hold_ticks == '0) ? HOLD_W'(1) : cfg.hold_ticks;
    assign hold_inc  = hold_cnt_reg + HOLD_W'(1);
    assign limit_eff = (cfg.count_limit > MAX_COUNT) ? MAX_COUNT : cfg.count_limit;

    always_comb begin
        data_now = data_reg;
        result.shift_clock  = 1'b0;
        result.latch_strobe = 1'b0;
        result.digit_enable = '0;
        unique case (phase_reg)
            PH_CLK_HIGH: begin
                data_now = segments[bit_reg];
                result.shift_clock = 1'b1;
            end
            PH_CLK_LOW: begin
                data_now = segments[bit_reg];
            end
            PH_LATCH: begin
                result.latch_strobe = 1'b1;
            end
            PH_HOLD: begin
                result.digit_enable = DIGITS'(1) << digit_reg;
            end
            default: ;
        endcase
        result.serial_data = data_now;
        result.shown_count = count_reg;
    end

    always_comb begin
        phase_next    = phase_reg;
        digit_next    = digit_reg;
        bit_next      = bit_reg;
        hold_cnt_next = hold_cnt_reg;
        data_next     = data_reg;
        count_next    = count_reg;
        carry         = 1'b1;
        for (int i = 0; i < DIGITS; i++) begin
            bcd_next[i] = bcd_reg[i];
        end
        if (adv) begin
            data_next = data_now;
            unique case (phase_reg)
                PH_CLK_HIGH: phase_next = PH_CLK_LOW;
                PH_CLK_LOW: begin
                    if (bit_reg == BIT_W'(SEG_BITS-1)) begin
                        bit_next   = '0;
                        phase_next = PH_LATCH;
                    end else begin
                        bit_next   = bit_reg + BIT_W'(1);
                        phase_next = PH_CLK_HIGH;
                    end
                end
                PH_LATCH: begin
                    hold_cnt_next = '0;
                    phase_next    = PH_HOLD;
                end
                PH_HOLD: begin
                    hold_cnt_next = hold_inc;
                    if (hold_inc >= hold_eff || hold_inc == '0) begin
                        hold_cnt_next = '0;
                        phase_next    = PH_CLK_HIGH;
                        if (digit_reg == DIG_W'(DIGITS-1)) begin
                            digit_next = '0;
                            if (count_reg >= limit_eff) begin
                                count_next = '0;
                                for (int i = 0; i < DIGITS; i++) begin
                                    bcd_next[i] = 4'd0;
                                end
                            end else begin
                                count_next = count_reg + COUNT_W'(1);
                                // ripple the decimal carry up from units
                                for (int i = 0; i < DIGITS; i++) begin
                                    if (carry) begin
                                        if (bcd_reg[i] == 4'd9) begin
                                            bcd_next[i] = 4'd0;
                                        end else begin
                                            bcd_next[i] = bcd_reg[i] + 4'd1;
                                            carry       = 1'b0;
                                        end
                                    end
                                end
                            end
                        end else begin
                            digit_next = digit_reg + DIG_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_CLK_HIGH;
            digit_reg    <= '0;
            bit_reg      <= '0;
            hold_cnt_reg <= '0;
            data_reg     <= 1'b0;
            count_reg    <= '0;
            for (int i = 0; i < DIGITS; i++) begin
                bcd_reg[i] <= 4'd0;
            end
        end else begin
            phase_reg    <= phase_next;
            digit_reg    <= digit_next;
            bit_reg      <= bit_next;
            hold_cnt_reg <= hold_cnt_next;
            data_reg     <= data_next;
            count_reg    <= count_next;
            for (int i = 0; i < DIGITS; i++) begin
                bcd_reg[i] <= bcd_next[i];
            end
        end
    end

endmodule

// ===== tb/seven_segment_scan_counter_tb.sv =====
// ---------------------------------------------------------------------------
// seven_segment_scan_counter_tb
// Drives tick transactions and register writes into the scan counter, keeps a
// step-by-step model of the scan sequencer and compares every returned pin
// transaction field by field against it, with random gaps on both channels.
// ---------------------------------------------------------------------------
module seven_segment_scan_counter_tb;
    import ssc_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam logic [ADDR_W-1:0] HOLD_ADDR  = {REG_HOLD, 2'b00};
    localparam logic [ADDR_W-1:0] LIMIT_ADDR = {REG_LIMIT, 2'b00};

    class scan_scoreboard;
        // segment bytes for digits 9 down to 0, packed
        localparam logic [79:0] GLYPHS = 80'h90_80_F8_82_92_99_B0_A4_F9_C0;

        logic [HOLD_W-1:0]  hold_ticks;
        logic [COUNT_W-1:0] count_limit;
        logic [COUNT_W-1:0] count;
        logic [DIG_W-1:0]   digit;
        ssc_phase_t         step;
        logic [BIT_W-1:0]   bit_pos;
        logic [HOLD_W-1:0]  held;
        logic               data_line;
        ssc_result_t        expected_pins[$];
        int                 errors;

        function new();
            hold_ticks  = HOLD_RESET;
            count_limit = LIMIT_RESET;
            count       = '0;
            digit       = '0;
            step        = PH_CLK_HIGH;
            bit_pos     = '0;
            held        = '0;
            data_line   = 1'b0;
            errors      = 0;
        endfunction

        function int pending();
            return expected_pins.size();
        endfunction

        function logic [7:0] glyph();
            int unsigned weight;
            int unsigned value;
            weight = 1;
            for (int k = int'(digit) + 1; k < DIGITS; k++) weight *= 10;
            value = (int'(count) / weight) % 10;
            return GLYPHS[value*8 +: 8];
        endfunction

        function void note_tick(logic advance);
            ssc_result_t        pins;
            logic [HOLD_W-1:0]  hold_len;
            logic [COUNT_W-1:0] cap;
            logic [7:0]         seg;
            hold_len = (hold_ticks == '0) ? HOLD_W'(1) : hold_ticks;
            pins = '0;
            pins.serial_data = data_line;
            case (step)
                PH_CLK_HIGH, PH_CLK_LOW: begin
                    seg = glyph();
                    pins.serial_data = seg[bit_pos];
                    pins.shift_clock = (step == PH_CLK_HIGH);
                end
                PH_LATCH: pins.latch_strobe = 1'b1;
                default: pins.digit_enable = DIGITS'(1) << digit;
            endcase
            pins.shown_count = count;
            expected_pins.push_back(pins);

            if (!advance) return;
            data_line = pins.serial_data;
            case (step)
                PH_CLK_HIGH: step = PH_CLK_LOW;
                PH_CLK_LOW: begin
                    if (int'(bit_pos) + 1 >= SEG_BITS) begin
                        bit_pos = '0;
                        step    = PH_LATCH;
                    end else begin
                        bit_pos = bit_pos + BIT_W'(1);
                        step    = PH_CLK_HIGH;
                    end
                end
                PH_LATCH: begin
                    held = '0;
                    step = PH_HOLD;
                end
                default: begin
                    held = held + HOLD_W'(1);
                    // a hold shortened mid-digit ends on the next tick
                    if (held >= hold_len || held == '0) begin
                        held = '0;
                        step = PH_CLK_HIGH;
                        if (int'(digit) + 1 >= DIGITS) begin
                            cap   = (count_limit > MAX_COUNT) ? MAX_COUNT : count_limit;
                            digit = '0;
                            count = (count >= cap) ? '0 : count + COUNT_W'(1);
                        end else begin
                            digit = digit + DIG_W'(1);
                        end
                    end
                end
            endcase
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0d got %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_pins(ssc_result_t got);
            ssc_result_t want;
            if (expected_pins.size() == 0) begin
                $display("%0t: unexpected transaction, expected none got count %0d",
                         $time, got.shown_count);
                errors++;
                return;
            end
            want = expected_pins.pop_front();
            compare("serial_data", want.serial_data, got.serial_data);
            compare("shift_clock", want.shift_clock, got.shift_clock);
            compare("latch_strobe", want.latch_strobe, got.latch_strobe);
            compare("digit_enable", want.digit_enable, got.digit_enable);
            compare("shown_count", want.shown_count, got.shown_count);
        endfunction
    endclass

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [ADDR_W-1:0]  paddr    = '0;
    logic [31:0]        pwdata   = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid  = 1'b0;
    logic               s_ready;
    logic               s_tick   = 1'b0;
    logic               m_valid;
    logic               m_ready  = 1'b0;
    logic               m_serial_data;
    logic               m_shift_clock;
    logic               m_latch_strobe;
    logic [DIGITS-1:0]  m_digit_enable;
    logic [COUNT_W-1:0] m_shown_count;

    scan_scoreboard sb = new();
    bit             steady = 1'b0;
    int             cycles = 0;
    int             stall_left = 0;
    ssc_result_t    seen;

    seven_segment_scan_counter DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_tick         (s_tick),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_serial_data  (m_serial_data),
        .m_shift_clock  (m_shift_clock),
        .m_latch_strobe (m_latch_strobe),
        .m_digit_enable (m_digit_enable),
        .m_shown_count  (m_shown_count)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen.serial_data  = m_serial_data;
            seen.shift_clock  = m_shift_clock;
            seen.latch_strobe = m_latch_strobe;
            seen.digit_enable = m_digit_enable;
            seen.shown_count  = m_shown_count;
            sb.check_pins(seen);
        end
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if (!steady) stall_left = pick_gap();
        end
    end

    task automatic push_tick(input logic t);
        s_valid <= 1'b1;
        s_tick  <= t;
        do @(posedge aclk); while (!s_ready);
        sb.note_tick(t);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        if (addr == HOLD_ADDR) sb.hold_ticks = value[HOLD_W-1:0];
        else sb.count_limit = value[COUNT_W-1:0];
    endtask

    task automatic run_ticks(input int n, input int pct_one);
        int gap;
        for (int i = 0; i < n; i++) begin
            push_tick($urandom_range(0, 99) < pct_one);
            gap = steady ? 0 : pick_gap();
            if ($urandom_range(0, 199) == 0) begin
                wait_idle();
            end else if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    initial begin
        logic [HOLD_W-1:0]  hold_pick;
        logic [COUNT_W-1:0] limit_pick;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // low ticks hold everything, then run into the first digit's hold
        push_tick(1'b0);
        push_tick(1'b0);
        repeat (22) push_tick(1'b1);
        push_tick(1'b0);

        // shorter hold while already past it: ends on the next tick
        wait_idle();
        write_reg(HOLD_ADDR, 32'd3);
        run_ticks(20, 90);
        wait_idle();
        run_ticks(20, 90);

        // zero hold acts as one, zero limit pins the count at zero
        wait_idle();
        write_reg(HOLD_ADDR, 32'd0);
        write_reg(LIMIT_ADDR, 32'd0);
        run_ticks(80, 95);

        // limit beyond 9999, run long enough for a few count steps
        wait_idle();
        write_reg(HOLD_ADDR, 32'd1);
        write_reg(LIMIT_ADDR, 32'd16383);
        steady = 1'b1;
        run_ticks(90, 100);
        steady = 1'b0;
        run_ticks(80, 97);

        // count now at or above the limit, wraps at the end of the scan
        wait_idle();
        write_reg(LIMIT_ADDR, 32'd1);
        run_ticks(80, 92);

        // longest hold
        wait_idle();
        write_reg(HOLD_ADDR, 32'd255);
        write_reg(LIMIT_ADDR, 32'd1);
        run_ticks(70, 95);

        for (int p = 0; p < 2; p++) begin
            wait_idle();
            steady = (p % 3 == 0);
            case ($urandom_range(0, 5))
                0: hold_pick = 8'd0;
                1: hold_pick = 8'd1;
                2: hold_pick = 8'd2;
                3: hold_pick = HOLD_W'($urandom_range(1, 255));
                default: hold_pick = HOLD_W'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 7))
                0: limit_pick = 14'd0;
                1: limit_pick = 14'd1;
                2: limit_pick = 14'd9;
                3: limit_pick = 14'd9999;
                4: limit_pick = 14'd16383;
                5: limit_pick = COUNT_W'($urandom_range(0, 16383));
                default: limit_pick = COUNT_W'($urandom_range(0, 20));
            endcase
            write_reg(HOLD_ADDR, {24'd0, hold_pick});
            if (p % 2 == 0) write_reg(LIMIT_ADDR, {18'd0, limit_pick});
            run_ticks(40, $urandom_range(60, 100));
        end
        steady = 1'b0;

        wait_idle();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
